### rtl/lhdc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the LED heat map core.
package lhdc_pkg;

	localparam int HEAT_W     = 32;
	localparam int SMOOTH_W   = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int RATIO_W    = 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_COOLING_FACTOR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HEAT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_HEAT      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_ENABLE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HOT_COLOR      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_COLD_COLOR     = 3'd5;

	// Configuration reset values
	localparam logic [15:0] COOLING_RST = 16'd655;
	localparam logic [15:0] PRESS_RST   = 16'd1000;
	localparam logic [15:0] HOLD_RST    = 16'd10;
	localparam logic [23:0] HOT_RST     = 24'hFF0000;
	localparam logic [23:0] COLD_RST    = 24'h0000FF;

	localparam logic       MODE_QUERY = 1'b1;
	// Hold ticks folded into the fixed part of the color ceiling
	localparam logic [6:0] HOLD_TICKS = 7'd100;
	// Blend ratio that selects the hot color outright
	localparam logic [RATIO_W:0] RATIO_HOT = 9'd256;

	typedef struct packed {
		logic       mode;
		logic [5:0] led_index;
		logic       is_key_led;
		logic       key_newly_pressed;
		logic       key_held;
		logic       mirror_is_key_led;
		logic       mirror_newly_pressed;
		logic       mirror_held;
		logic       last_of_tick;
	} lhdc_req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} lhdc_rsp_t;

	typedef struct packed {
		logic busy;
		logic done;
	} lhdc_div_stat_t;

endpackage

### rtl/lhdc_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the LED heat map core.
interface lhdc_req_if
	import lhdc_pkg::*;
();
	logic      valid;
	logic      ready;
	lhdc_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lhdc_rsp_if
	import lhdc_pkg::*;
();
	logic      valid;
	logic      ready;
	lhdc_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/lhdc_heat_mem.sv
`timescale 1ns / 1ps
// Per-LED heat memory: one read and one write port, entries read as zero until written.
module lhdc_heat_mem
	import lhdc_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [HEAT_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [HEAT_W-1:0] wr_data
);

	logic [HEAT_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [HEAT_W-1:0] rd_mem_q;
	logic              rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_mem_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// unwritten entries hold their reset value of zero
	assign rd_data = rd_vld_q ? rd_mem_q : '0;

endmodule

### rtl/lhdc_div.sv
`timescale 1ns / 1ps
// Restoring divider for the blend ratio: one quotient bit per cycle.
module lhdc_div
	import lhdc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [HEAT_W-1:0]  dividend,
	input  logic [HEAT_W-1:0]  divisor,
	output lhdc_div_stat_t     stat,
	output logic [RATIO_W-1:0] quot
);

	localparam int CntW = $clog2(RATIO_W);

	logic [HEAT_W:0]          rem_q;
	logic [RATIO_W-1:0]       quot_q;
	logic [CntW-1:0]          cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [HEAT_W:0]          trial;
	logic                     fits;

	// dividend stays below divisor, so the shifted remainder fits one extra bit
	assign trial = {rem_q[HEAT_W-1:0], 1'b0};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, dividend};
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? (trial - {1'b0, divisor}) : trial;
			quot_q <= {quot_q[RATIO_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(RATIO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quot_q;

endmodule

### rtl/led_heatmap_decay_color_core.sv
`timescale 1ns / 1ps
// Sequence: an update steps through accept, gain add, cooling multiply and write back;
// a last-of-tick update then runs the maximum smoothing.
// A query picks cold or hot at zero or full heat, else it runs the 8-step divider first.
// One request is in flight at a time; a finished color waits in the output register
// while the next request is taken. Reset clears all heat and both maxima, restores config.
module led_heatmap_decay_color_core
	import lhdc_pkg::*;
#(
	parameter int LED_COUNT = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	lhdc_req_if.sink              req,
	lhdc_rsp_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AddrW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam logic [8:0] LedLimit = 9'(LED_COUNT);

	typedef enum logic [11:0] {
		ST_IDLE = 12'b0000_0000_0001,
		ST_ADD  = 12'b0000_0000_0010,
		ST_MUL  = 12'b0000_0000_0100,
		ST_WB   = 12'b0000_0000_1000,
		ST_SDIF = 12'b0000_0001_0000,
		ST_SP0  = 12'b0000_0010_0000,
		ST_SP1  = 12'b0000_0100_0000,
		ST_SDEC = 12'b0000_1000_0000,
		ST_SSUB = 12'b0001_0000_0000,
		ST_QCHK = 12'b0010_0000_0000,
		ST_QDIV = 12'b0100_0000_0000,
		ST_QOUT = 12'b1000_0000_0000
	} state_t;

	// Heat gain of one key: press heat on a new press plus hold heat while held
	function automatic logic [16:0] key_gain(input logic newly, input logic held,
			input logic [15:0] ph, input logic [15:0] hh);
		logic [16:0] g;
		g = (newly ? {1'b0, ph} : 17'd0) + (held ? {1'b0, hh} : 17'd0);
		return g;
	endfunction

	// Linear blend of one 8-bit channel, ratio in Q1.8 (256 selects hot)
	function automatic logic [7:0] blend(input logic [7:0] c, input logic [7:0] h,
			input logic [RATIO_W:0] r);
		logic [16:0] acc;
		acc = 17'(c) * 17'(RATIO_HOT - r) + 17'(h) * 17'(r);
		return acc[15:8];
	endfunction

	// Configuration registers
	logic [15:0] cooling_factor_q;
	logic [15:0] press_heat_q;
	logic [15:0] hold_heat_q;
	logic        mirror_enable_q;
	logic [23:0] hot_color_q;
	logic [23:0] cold_color_q;

	// Control and architectural state
	state_t                state_q;
	state_t                state_n;
	logic [HEAT_W-1:0]     tick_max_q;
	logic [SMOOTH_W-1:0]   smoothed_q;
	logic                  rsp_valid_q;

	// Datapath registers
	lhdc_req_t             item_q;
	logic                  in_range_q;
	logic [17:0]           delta_q;
	logic [HEAT_W-1:0]     ceil_q;
	logic [HEAT_W-1:0]     sat_q;
	logic [48:0]           prod_q;
	logic [SMOOTH_W-1:0]   diff_q;
	logic [39:0]           pp_lo_q;
	logic [39:0]           pp_hi_q;
	logic [46:0]           dec_q;
	logic [RATIO_W:0]      ratio_q;
	lhdc_rsp_t             rsp_data_q;

	// Combinational signals
	logic                  req_fire;
	logic                  in_range;
	logic [16:0]           own_gain;
	logic [16:0]           mir_gain;
	logic [22:0]           ceil_fix;
	logic [HEAT_W-1:0]     ceil_smooth;
	logic [HEAT_W-1:0]     mem_rd;
	logic [HEAT_W-1:0]     heat_cur;
	logic [HEAT_W:0]       heat_sum;
	logic [16:0]           keep;
	logic [HEAT_W-1:0]     heat_new;
	logic [SMOOTH_W-1:0]   smooth_t;
	logic                  smooth_le;
	logic [63:0]           dec_sum;
	logic                  heat_zero;
	logic                  heat_ge;
	logic                  div_start;
	lhdc_div_stat_t        div_stat;
	logic [RATIO_W-1:0]    div_quot;
	logic                  rsp_load;

	// Configuration writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooling_factor_q <= COOLING_RST;
			press_heat_q     <= PRESS_RST;
			hold_heat_q      <= HOLD_RST;
			mirror_enable_q  <= 1'b0;
			hot_color_q      <= HOT_RST;
			cold_color_q     <= COLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COOLING_FACTOR: cooling_factor_q <= cfg_data[15:0];
				CFG_PRESS_HEAT:     press_heat_q     <= cfg_data[15:0];
				CFG_HOLD_HEAT:      hold_heat_q      <= cfg_data[15:0];
				CFG_MIRROR_ENABLE:  mirror_enable_q  <= cfg_data[0];
				CFG_HOT_COLOR:      hot_color_q      <= cfg_data[23:0];
				CFG_COLD_COLOR:     cold_color_q     <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// Take a request only when the sequencer is free
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign in_range  = ({3'b000, req.data.led_index} < LedLimit);

	assign own_gain = key_gain(req.data.key_newly_pressed, req.data.key_held,
		press_heat_q, hold_heat_q);
	assign mir_gain = key_gain(req.data.mirror_newly_pressed, req.data.mirror_held,
		press_heat_q, hold_heat_q);

	// Ceiling: fixed part from the gains, or the smoothed maximum if larger
	assign ceil_fix    = {7'd0, press_heat_q} + 23'(hold_heat_q) * 23'(HOLD_TICKS) + 23'd1;
	assign ceil_smooth = smoothed_q[SMOOTH_W-1:16];

	// Heat memory: read at accept, write back after cooling
	lhdc_heat_mem #(
		.DEPTH(LED_COUNT),
		.AW   (AddrW)
	) u_heat_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (req_fire && in_range),
		.rd_addr(AddrW'(req.data.led_index)),
		.rd_data(mem_rd),
		.wr_en  (state_q == ST_WB && in_range_q),
		.wr_addr(AddrW'(item_q.led_index)),
		.wr_data(heat_new)
	);

	// Out-of-range LEDs read as cold
	assign heat_cur = in_range_q ? mem_rd : '0;
	assign heat_sum = {1'b0, heat_cur} + 33'(delta_q);
	assign keep     = 17'h10000 - {1'b0, cooling_factor_q};
	assign heat_new = prod_q[47:16];

	// Smoothing target and the scaled decrement
	assign smooth_t  = {tick_max_q, 16'd0};
	assign smooth_le = (smoothed_q <= smooth_t);
	assign dec_sum   = {pp_hi_q, 24'd0} + {24'd0, pp_lo_q};

	// Query classification
	assign heat_zero = (heat_cur == '0);
	assign heat_ge   = (heat_cur >= ceil_q);
	assign div_start = (state_q == ST_QCHK) && !heat_zero && !heat_ge && !div_stat.busy;

	lhdc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(heat_cur),
		.divisor (ceil_q),
		.stat    (div_stat),
		.quot    (div_quot)
	);

	// Hold the color until the output register frees up
	assign rsp_load = (state_q == ST_QOUT) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					state_n = (req.data.mode == MODE_QUERY) ? ST_QCHK : ST_ADD;
				end
			end
			ST_ADD:  state_n = ST_MUL;
			ST_MUL:  state_n = ST_WB;
			ST_WB:   state_n = item_q.last_of_tick ? ST_SDIF : ST_IDLE;
			ST_SDIF: state_n = smooth_le ? ST_IDLE : ST_SP0;
			ST_SP0:  state_n = ST_SP1;
			ST_SP1:  state_n = ST_SDEC;
			ST_SDEC: state_n = ST_SSUB;
			ST_SSUB: state_n = ST_IDLE;
			ST_QCHK: state_n = (heat_zero || heat_ge) ? ST_QOUT : ST_QDIV;
			ST_QDIV: state_n = div_stat.done ? ST_QOUT : ST_QDIV;
			ST_QOUT: state_n = rsp_load ? ST_IDLE : ST_QOUT;
			default: state_n = ST_IDLE;
		endcase
	end

	// Sequencer, tick maximum, smoothed maximum, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tick_max_q  <= '0;
			smoothed_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			case (state_q)
				ST_WB: begin
					if (in_range_q && (heat_new > tick_max_q)) begin
						tick_max_q <= heat_new;
					end
				end
				ST_SDIF: begin
					// never fall below the tick maximum
					if (smooth_le) begin
						smoothed_q <= smooth_t;
						tick_max_q <= '0;
					end
				end
				ST_SSUB: begin
					smoothed_q <= smoothed_q - {1'b0, dec_q};
					tick_max_q <= '0;
				end
				default: ;
			endcase
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req_fire) begin
			item_q     <= req.data;
			in_range_q <= in_range;
			delta_q    <= (req.data.is_key_led ? {1'b0, own_gain} : 18'd0)
				+ ((mirror_enable_q && req.data.mirror_is_key_led) ? {1'b0, mir_gain} : 18'd0);
			ceil_q     <= (ceil_smooth > {9'd0, ceil_fix}) ? ceil_smooth : {9'd0, ceil_fix};
		end
		case (state_q)
			// saturate the gained heat at the 32-bit limit
			ST_ADD:  sat_q   <= heat_sum[HEAT_W] ? '1 : heat_sum[HEAT_W-1:0];
			ST_MUL:  prod_q  <= 49'(sat_q) * 49'(keep);
			ST_SDIF: diff_q  <= smoothed_q - smooth_t;
			ST_SP0:  pp_lo_q <= 40'(diff_q[23:0]) * 40'(cooling_factor_q);
			ST_SP1:  pp_hi_q <= 40'(diff_q[47:24]) * 40'(cooling_factor_q);
			// half the cooling rate: drop 17 fraction bits
			ST_SDEC: dec_q   <= dec_sum[63:17];
			ST_QCHK: ratio_q <= heat_zero ? '0 : RATIO_HOT;
			ST_QDIV: begin
				if (div_stat.done) begin
					ratio_q <= {1'b0, div_quot};
				end
			end
			default: ;
		endcase
		if (rsp_load) begin
			rsp_data_q.red   <= blend(cold_color_q[23:16], hot_color_q[23:16], ratio_q);
			rsp_data_q.green <= blend(cold_color_q[15:8], hot_color_q[15:8], ratio_q);
			rsp_data_q.blue  <= blend(cold_color_q[7:0], hot_color_q[7:0], ratio_q);
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

endmodule

### rtl/lhdc_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the LED heat map core and their binding.
module lhdc_checker
	import lhdc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_ready,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input lhdc_rsp_t rsp_data
);

	// one request at a time: ready drops after every accept
	a_single_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while previous one still in progress");

	// a color is produced only by a busy sequencer
	a_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("response appeared without a request in progress");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("stalled response dropped or changed");

endmodule

bind led_heatmap_decay_color_core lhdc_checker u_lhdc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_data (rsp.data)
);

### tb/sv/lhdc_heat_tracker.sv
`timescale 1ns / 1ps
// Heat map tracker: follows requests and config writes, predicts and checks colors.
module lhdc_heat_tracker
	import lhdc_pkg::*;
#(
	parameter int LED_COUNT = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	lhdc_req_if                   req,
	lhdc_rsp_if                   rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    colors_left,
	output int                    updates_seen,
	output int                    ticks_closed,
	output int                    colors_checked,
	output int                    blends_checked
);

	localparam int PRINT_CAP = 30;

	logic [15:0] cooling, press, hold;
	logic        mirror_on;
	logic [23:0] hot, cold;

	logic [HEAT_W-1:0]   heat_map [LED_COUNT];
	logic [HEAT_W-1:0]   tick_peak;
	logic [SMOOTH_W-1:0] smooth_peak;

	lhdc_rsp_t colors_due [$];
	int        bad_n, upd_n, tick_n, color_n, blend_n;

	task automatic report_mismatch(input string what, input int got, input int want);
		bad_n++;
		if (bad_n <= PRINT_CAP)
			$display("%0t: %s mismatch: got %0d, want %0d", $time, what, got, want);
	endtask

	function automatic logic [31:0] key_gain(input logic newly, input logic held);
		logic [31:0] g;
		g = '0;
		if (newly) g += 32'(press);
		if (held) g += 32'(hold);
		return g;
	endfunction

	function automatic logic [7:0] mix(input logic [7:0] c, input logic [7:0] h,
		input logic [31:0] ratio);
		logic [31:0] acc;
		acc = (32'(c) * (32'd256 - ratio) + 32'(h) * ratio) >> 8;
		return acc[7:0];
	endfunction

	function automatic lhdc_rsp_t color_for(input lhdc_req_t r, output logic blended);
		logic [63:0] heat, ceil_s, ceil_f, ceiling, ratio;
		lhdc_rsp_t   c;
		heat    = (r.led_index < LED_COUNT) ? 64'(heat_map[r.led_index]) : 64'd0;
		ceil_s  = 64'(smooth_peak >> 16);
		ceil_f  = 64'(press) + 64'(hold) * 64'(HOLD_TICKS) + 64'd1;
		ceiling = (ceil_s > ceil_f) ? ceil_s : ceil_f;
		blended = 1'b0;
		if (heat == 0) begin
			c = lhdc_rsp_t'(cold);
		end else if (heat >= ceiling) begin
			c = lhdc_rsp_t'(hot);
		end else begin
			blended = 1'b1;
			ratio   = (heat << 8) / ceiling;
			c.red   = mix(cold[23:16], hot[23:16], ratio[31:0]);
			c.green = mix(cold[15:8], hot[15:8], ratio[31:0]);
			c.blue  = mix(cold[7:0], hot[7:0], ratio[31:0]);
		end
		return c;
	endfunction

	task automatic heat_update(input lhdc_req_t r);
		logic [31:0] gain;
		logic [32:0] gained;
		logic [63:0] scaled, floor_q, dec;
		if (r.led_index < LED_COUNT) begin
			gain = '0;
			if (r.is_key_led) gain += key_gain(r.key_newly_pressed, r.key_held);
			if (mirror_on && r.mirror_is_key_led)
				gain += key_gain(r.mirror_newly_pressed, r.mirror_held);
			gained = {1'b0, heat_map[r.led_index]} + {1'b0, gain};
			if (gained[32]) gained = {1'b0, 32'hFFFF_FFFF};
			scaled = (64'(gained) * (64'd65536 - 64'(cooling))) >> 16;
			heat_map[r.led_index] = scaled[31:0];
			if (scaled[31:0] > tick_peak) tick_peak = scaled[31:0];
		end
		if (r.last_of_tick) begin
			floor_q = 64'(tick_peak) << 16;
			if (64'(smooth_peak) <= floor_q) begin
				smooth_peak = floor_q[SMOOTH_W-1:0];
			end else begin
				dec = ((64'(smooth_peak) - floor_q) * 64'(cooling)) >> 17;
				smooth_peak = smooth_peak - dec[SMOOTH_W-1:0];
			end
			tick_peak = '0;
			tick_n++;
		end
		upd_n++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		lhdc_rsp_t want;
		logic      blended;
		if (!arst_n) begin
			cooling   = COOLING_RST;
			press     = PRESS_RST;
			hold      = HOLD_RST;
			mirror_on = 1'b0;
			hot       = HOT_RST;
			cold      = COLD_RST;
			for (int i = 0; i < LED_COUNT; i++) heat_map[i] = '0;
			tick_peak   = '0;
			smooth_peak = '0;
			colors_due.delete();
			bad_n   = 0;
			upd_n   = 0;
			tick_n  = 0;
			color_n = 0;
			blend_n = 0;
		end else begin
			// Check the returned color before taking the next request of this edge
			if (rsp.valid && rsp.ready) begin
				if (colors_due.size() == 0) begin
					report_mismatch("unrequested color", int'(rsp.data), -1);
				end else begin
					want = colors_due.pop_front();
					if (rsp.data.red !== want.red)
						report_mismatch("red", int'(rsp.data.red), int'(want.red));
					if (rsp.data.green !== want.green)
						report_mismatch("green", int'(rsp.data.green), int'(want.green));
					if (rsp.data.blue !== want.blue)
						report_mismatch("blue", int'(rsp.data.blue), int'(want.blue));
					color_n++;
				end
			end
			if (req.valid && req.ready) begin
				if (req.data.mode == MODE_QUERY) begin
					colors_due.push_back(color_for(req.data, blended));
					if (blended) blend_n++;
				end else begin
					heat_update(req.data);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_COOLING_FACTOR: cooling   = cfg_data[15:0];
					CFG_PRESS_HEAT:     press     = cfg_data[15:0];
					CFG_HOLD_HEAT:      hold      = cfg_data[15:0];
					CFG_MIRROR_ENABLE:  mirror_on = cfg_data[0];
					CFG_HOT_COLOR:      hot       = cfg_data[23:0];
					CFG_COLD_COLOR:     cold      = cfg_data[23:0];
					default: ;
				endcase
			end
		end
		mismatches     <= bad_n;
		colors_left    <= colors_due.size();
		updates_seen   <= upd_n;
		ticks_closed   <= tick_n;
		colors_checked <= color_n;
		blends_checked <= blend_n;
	end

endmodule

### tb/sv/led_heatmap_decay_color_core_test.sv
`timescale 1ns / 1ps
// Top of the LED heat map core testbench: clock, reset, stimulus and verdict.
module led_heatmap_decay_color_core_test;
	import lhdc_pkg::*;

	localparam int LED_COUNT     = 64;
	// Quiet cycles (nothing accepted on either channel) before the run is called hung
	localparam int STALL_LIMIT   = 5000;
	// Margin for an update with smoothing to finish after its acceptance
	localparam int SETTLE_CYCLES = 16;
	localparam int SEGMENT_ITEMS = 105;

	localparam logic MODE_UPDATE = 1'b0;

	// Indexes past the last register: writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	// Key flag groups, ordered as in the request:
	// is_key_led, key_newly_pressed, key_held, mirror_is_key_led, mirror_newly_pressed,
	// mirror_held
	localparam logic [5:0] KEYS_NONE    = 6'b000_000;
	localparam logic [5:0] KEY_PRESS    = 6'b110_000;
	localparam logic [5:0] KEY_BOTH     = 6'b111_000;
	localparam logic [5:0] MIRROR_PRESS = 6'b000_110;
	localparam logic [5:0] MIRROR_ONLY  = 6'b011_111;
	localparam logic [5:0] KEYS_ALL     = 6'b111_111;

	typedef struct packed {
		logic [15:0] cooling;
		logic [15:0] press;
		logic [15:0] hold;
		logic        mirror;
		logic [23:0] hot;
		logic [23:0] cold;
	} heat_setup_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles;
	int setups_applied;
	int mismatches, colors_left, updates_seen, ticks_closed, colors_checked, blends_checked;

	lhdc_req_if req ();
	lhdc_rsp_if rsp ();

	led_heatmap_decay_color_core #(
		.LED_COUNT(LED_COUNT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	lhdc_heat_tracker #(
		.LED_COUNT(LED_COUNT)
	) u_tracker (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.colors_left(colors_left),
		.updates_seen(updates_seen),
		.ticks_closed(ticks_closed),
		.colors_checked(colors_checked),
		.blends_checked(blends_checked)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Color receiver: drop ready on a random share of cycles set by the current phase
	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: restart the count on any accepted request or color
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("Hung: %0d cycles without progress, %0d colors outstanding",
					quiet_cycles, colors_left);
				$display("led_heatmap_decay_color_core verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic lhdc_req_t update_req(input logic [5:0] led, input logic [5:0] keys,
		input logic last);
		return {MODE_UPDATE, led, keys, last};
	endfunction

	function automatic lhdc_req_t query_req(input logic [5:0] led, input logic last);
		return {MODE_QUERY, led, 6'($urandom), last};
	endfunction

	// Keep most traffic on a handful of LEDs so heat builds up; spread the rest
	function automatic logic [5:0] pick_led();
		return ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(7));
	endfunction

	function automatic heat_setup_t rand_setup();
		heat_setup_t s;
		s.cooling = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000));
		s.press   = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(5000));
		s.hold    = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(200));
		s.mirror  = 1'($urandom);
		s.hot     = 24'($urandom);
		s.cold    = 24'($urandom);
		return s;
	endfunction

	// Present one request, idling first at the phase's rate, and hold it until accepted
	task automatic send_request(input lhdc_req_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.data  <= item;
		do @(posedge clk); while (!req.ready);
	endtask

	// Hold off the sender until every queried color is back and the core has settled
	task automatic drain_colors();
		req.valid <= 1'b0;
		do @(posedge clk); while (colors_left != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all six registers back to back, then poke one unused index
	task automatic apply_setup(input heat_setup_t s);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_COOLING_FACTOR;
		cfg_data  <= 24'(s.cooling);
		@(posedge clk);
		cfg_index <= CFG_PRESS_HEAT;
		cfg_data  <= 24'(s.press);
		@(posedge clk);
		cfg_index <= CFG_HOLD_HEAT;
		cfg_data  <= 24'(s.hold);
		@(posedge clk);
		cfg_index <= CFG_MIRROR_ENABLE;
		cfg_data  <= 24'(s.mirror);
		@(posedge clk);
		cfg_index <= CFG_HOT_COLOR;
		cfg_data  <= s.hot;
		@(posedge clk);
		cfg_index <= CFG_COLD_COLOR;
		cfg_data  <= s.cold;
		@(posedge clk);
		cfg_index <= ($urandom_range(1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI;
		cfg_data  <= 24'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		setups_applied++;
	endtask

	// Random traffic shaped as ticks: a run of LED updates closed by the last-of-tick
	// flag, then a few color queries, with the odd fully random request as noise
	task automatic run_ticks(input int n_items);
		int sent;
		int span;
		sent = 0;
		while (sent < n_items) begin
			span = $urandom_range(1, 8);
			for (int k = 0; k < span; k++) begin
				send_request(update_req(pick_led(), 6'($urandom), k == span - 1));
				sent++;
			end
			repeat ($urandom_range(0, 3)) begin
				send_request(query_req(pick_led(), 1'($urandom)));
				sent++;
			end
			if ($urandom_range(9) == 0) begin
				send_request(lhdc_req_t'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		// Drive every input to a known value before reset lifts
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		req.valid      = 1'b0;
		req.data       = '0;
		rsp.ready      = 1'b0;
		quiet_cycles   = 0;
		setups_applied = 0;
		send_idle_pct  = 14;
		recv_idle_pct  = 67;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration: zero heat, a blend, ignored mirror inputs, smoothing both ways
		send_request(query_req(6'd0, 1'b0));
		send_request(query_req(6'd63, 1'b0));
		send_request(update_req(6'd0, KEY_BOTH, 1'b0));
		send_request(query_req(6'd0, 1'b0));
		send_request(update_req(6'd0, MIRROR_ONLY, 1'b0));
		send_request(update_req(6'd63, KEYS_ALL, 1'b1));
		// Last flag on a query must not smooth
		send_request(query_req(6'd63, 1'b1));
		// Empty tick: maximum falls from above toward zero
		send_request(update_req(6'd5, KEYS_NONE, 1'b1));
		send_request(query_req(6'd0, 1'b0));
		drain_colors();

		// No cooling, full press heat, mirror on: reach and miss the ceiling by one
		apply_setup('{cooling: 16'd0, press: 16'hFFFF, hold: 16'd0, mirror: 1'b1,
			hot: 24'hFFFFFF, cold: 24'h000000});
		send_request(update_req(6'd1, KEY_PRESS | MIRROR_PRESS, 1'b0));
		send_request(query_req(6'd1, 1'b0));
		send_request(update_req(6'd2, KEY_PRESS, 1'b0));
		send_request(query_req(6'd2, 1'b0));
		send_request(update_req(6'd3, MIRROR_ONLY, 1'b1));
		send_request(query_req(6'd3, 1'b0));
		drain_colors();

		// Full cooling with every gain at its top
		apply_setup('{cooling: 16'hFFFF, press: 16'hFFFF, hold: 16'hFFFF, mirror: 1'b1,
			hot: 24'h000000, cold: 24'hFFFFFF});
		send_request(update_req(6'd4, KEYS_ALL, 1'b0));
		send_request(query_req(6'd4, 1'b0));
		send_request(update_req(6'd1, KEYS_ALL, 1'b1));
		send_request(query_req(6'd1, 1'b0));
		send_request(query_req(6'd63, 1'b0));
		drain_colors();

		// Random part in three idling phases, two register settings each
		for (int seg = 0; seg < 6; seg++) begin
			case (seg / 2)
				0: begin
					send_idle_pct = 14;
					recv_idle_pct = 67;
				end
				1: begin
					send_idle_pct = 67;
					recv_idle_pct = 14;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			apply_setup(rand_setup());
			run_ticks(SEGMENT_ITEMS / 2);
			// Pause with the core empty, then carry on under the same setting
			drain_colors();
			run_ticks(SEGMENT_ITEMS - SEGMENT_ITEMS / 2);
			drain_colors();
		end

		$display("Ran %0d heat updates over %0d ticks and %0d color queries (%0d blended)",
			updates_seen, ticks_closed, colors_checked, blends_checked);
		$display("under %0d register settings plus reset values, three idling phases",
			setups_applied);
		if (mismatches == 0 && colors_left == 0) begin
			$display("led_heatmap_decay_color_core verification clean");
		end else begin
			$display("led_heatmap_decay_color_core verification failed");
		end
		$finish;
	end

endmodule
